// ===== rtl/rbw_pkg.sv =====
// shared types and constants of the base relocation walker
package rbw_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_IMAGE_BASE      = 3'd0,
		CFG_FIXUP_BASE      = 3'd1,
		CFG_GIVEN_BASE      = 3'd2,
		CFG_HEADER_BASE     = 3'd3,
		CFG_USE_HEADER_BASE = 3'd4,
		CFG_PASS_MODE       = 3'd5,
		CFG_DIRECTORY_SIZE  = 3'd6
	} cfg_reg_e;

	// result kinds
	localparam logic [1:0] KIND_PATCH     = 2'd0;
	localparam logic [1:0] KIND_DONE      = 2'd1;
	localparam logic [1:0] KIND_BADTYPE   = 2'd2;
	localparam logic [1:0] KIND_MALFORMED = 2'd3;

	// relocation entry types
	localparam logic [3:0] TYPE_ABSOLUTE = 4'd0;
	localparam logic [3:0] TYPE_DIR64    = 4'd10;

	localparam logic [31:0] HEADER_BYTES = 32'd8;

	typedef struct packed {
		logic [63:0] image_base;
		logic [63:0] fixup_base;
		logic [63:0] given_preferred_base;
		logic [63:0] header_default_base;
		logic        use_header_base;
		logic        pass_mode;
		logic [31:0] directory_size;
	} cfg_t;

	typedef struct packed {
		logic [63:0] patch_address;
		logic [63:0] patch_delta;
		logic [1:0]  result_kind;
		logic        is_last;
	} result_t;

endpackage

// ===== rtl/pe_base_relocation_walker.sv =====
// Walks a PE32+ base relocation directory fed as 16-bit halfwords, one per cycle while m_tready stays high.
// A halfword lands in an input register, is stepped through the block header and
// entry logic, and any result sits in an output register; the block sustains one
// halfword per cycle while m_tready stays high, and the step logic with its 64-bit
// address add and delta subtract sets the clock.
// Check mode reports the first entry type other than absolute or dir64; apply mode
// emits one patch (address, delta) per dir64 entry. A result with tlast ends the
// walk; later halfwords are taken and dropped until reset.
module pe_base_relocation_walker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // [15:0] reloc_halfword
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,   // [63:0] patch_address, [127:64] patch_delta
	output logic          m_tlast,
	output logic [1:0]    m_tuser,   // [1:0] result_kind
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	rbw_pkg::cfg_t    cfg;
	rbw_pkg::result_t res;
	logic             res_valid;
	logic [15:0]      hw_s1;
	logic             vld_s1;
	logic             advance;

	// stage 1 request is stepped only when the result register can take it
	assign advance   = vld_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !vld_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hw_s1 <= s_tdata;
		end
	end

	rbw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rbw_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.hw        (hw_s1),
		.cfg       (cfg),
		.res       (res),
		.res_valid (res_valid)
	);

	rbw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.res_valid (res_valid),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// nothing follows the closing result of a walk
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result after end of walk");

	// only patches carry an address and delta
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != rbw_pkg::KIND_PATCH) |-> (m_tdata == '0))
		else $error("non-patch result with payload");

	// error kinds always end the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == rbw_pkg::KIND_MALFORMED ||
		             m_tuser == rbw_pkg::KIND_BADTYPE) |-> m_tlast)
		else $error("error result without tlast");

	// an empty result register never stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

// ===== rtl/rbw_cfg_regs.sv =====
// configuration registers of the base relocation walker
module rbw_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [63:0]   wr_data,
	output rbw_pkg::cfg_t cfg
);

	rbw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_base           <= '0;
			cfg_q.fixup_base           <= '0;
			cfg_q.given_preferred_base <= '0;
			cfg_q.header_default_base  <= '0;
			cfg_q.use_header_base      <= 1'b1;
			cfg_q.pass_mode            <= 1'b0;
			cfg_q.directory_size       <= '0;
		end else if (wr_en) begin
			case (rbw_pkg::cfg_reg_e'(wr_index))
				rbw_pkg::CFG_IMAGE_BASE:      cfg_q.image_base <= wr_data;
				rbw_pkg::CFG_FIXUP_BASE:      cfg_q.fixup_base <= wr_data;
				rbw_pkg::CFG_GIVEN_BASE:      cfg_q.given_preferred_base <= wr_data;
				rbw_pkg::CFG_HEADER_BASE:     cfg_q.header_default_base <= wr_data;
				rbw_pkg::CFG_USE_HEADER_BASE: cfg_q.use_header_base <= wr_data[0];
				rbw_pkg::CFG_PASS_MODE:       cfg_q.pass_mode <= wr_data[0];
				rbw_pkg::CFG_DIRECTORY_SIZE:  cfg_q.directory_size <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/rbw_walk.sv =====
// walk state and per-halfword step logic
module rbw_walk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [15:0]      hw,
	input  rbw_pkg::cfg_t    cfg,
	output rbw_pkg::result_t res,
	output logic             res_valid
);

	logic        in_header_q, in_header_d;
	logic [1:0]  header_index_q, header_index_d;
	logic [31:0] block_page_q, block_page_d;
	logic [31:0] block_bytes_q, block_bytes_d;
	logic [30:0] entries_left_q, entries_left_d;
	logic [32:0] bytes_consumed_q, bytes_consumed_d;
	logic        finished_q, finished_d;

	logic [31:0] bytes_new;
	logic [32:0] consumed_sum;
	logic [31:0] body_bytes;
	logic [30:0] entries_hdr;
	logic [30:0] entries_dec;
	logic        ended_hdr;
	logic        ended_entry;
	logic        malformed;
	logic [3:0]  entry_type;
	logic [63:0] pref_base;
	logic [63:0] delta;
	logic [63:0] addr;

	assign bytes_new    = {hw, block_bytes_q[15:0]};
	assign consumed_sum = bytes_consumed_q + {1'b0, bytes_new};
	assign body_bytes   = bytes_new - rbw_pkg::HEADER_BYTES;
	assign entries_hdr  = body_bytes[31:1];
	assign entries_dec  = entries_left_q - 31'd1;
	assign ended_hdr    = consumed_sum >= {1'b0, cfg.directory_size};
	assign ended_entry  = bytes_consumed_q >= {1'b0, cfg.directory_size};
	assign malformed    = (bytes_new < rbw_pkg::HEADER_BYTES) || bytes_new[0];
	assign entry_type   = hw[15:12];
	assign pref_base    = cfg.use_header_base ? cfg.header_default_base
	                                          : cfg.given_preferred_base;
	assign delta        = cfg.fixup_base - pref_base;
	assign addr         = cfg.image_base + {32'd0, block_page_q} + {52'd0, hw[11:0]};

	always_comb begin
		in_header_d      = in_header_q;
		header_index_d   = header_index_q;
		block_page_d     = block_page_q;
		block_bytes_d    = block_bytes_q;
		entries_left_d   = entries_left_q;
		bytes_consumed_d = bytes_consumed_q;
		finished_d       = finished_q;
		res              = '0;
		res_valid        = 1'b0;

		if (!finished_q) begin
			if (in_header_q) begin
				header_index_d = header_index_q + 2'd1;
				case (header_index_q)
					2'd0: block_page_d[15:0]   = hw;
					2'd1: block_page_d[31:16]  = hw;
					2'd2: block_bytes_d[15:0]  = hw;
					default: begin
						block_bytes_d[31:16] = hw;
						if (malformed) begin
							res.result_kind = rbw_pkg::KIND_MALFORMED;
							res.is_last     = 1'b1;
							res_valid       = 1'b1;
						end else begin
							entries_left_d   = entries_hdr;
							bytes_consumed_d = consumed_sum;
							if (entries_hdr == '0) begin
								if (ended_hdr) begin
									res.result_kind = rbw_pkg::KIND_DONE;
									res.is_last     = 1'b1;
									res_valid       = 1'b1;
								end
							end else begin
								in_header_d = 1'b0;
							end
						end
					end
				endcase
			end else begin
				entries_left_d = entries_dec;
				if (entries_dec == '0) begin
					in_header_d = 1'b1;
				end
				if (!cfg.pass_mode) begin
					if (entry_type != rbw_pkg::TYPE_ABSOLUTE &&
					    entry_type != rbw_pkg::TYPE_DIR64) begin
						res.result_kind = rbw_pkg::KIND_BADTYPE;
						res.is_last     = 1'b1;
						res_valid       = 1'b1;
					end else if (entries_dec == '0 && ended_entry) begin
						res.result_kind = rbw_pkg::KIND_DONE;
						res.is_last     = 1'b1;
						res_valid       = 1'b1;
					end
				end else if (entry_type == rbw_pkg::TYPE_DIR64) begin
					res.patch_address = addr;
					res.patch_delta   = delta;
					res.result_kind   = rbw_pkg::KIND_PATCH;
					res.is_last       = (entries_dec == '0) && ended_entry;
					res_valid         = 1'b1;
				end else if (entries_dec == '0 && ended_entry) begin
					res.result_kind = rbw_pkg::KIND_DONE;
					res.is_last     = 1'b1;
					res_valid       = 1'b1;
				end
			end
			if (res_valid && res.is_last) begin
				finished_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q      <= 1'b1;
			header_index_q   <= '0;
			block_page_q     <= '0;
			block_bytes_q    <= '0;
			entries_left_q   <= '0;
			bytes_consumed_q <= '0;
			finished_q       <= 1'b0;
		end else if (step_en) begin
			in_header_q      <= in_header_d;
			header_index_q   <= header_index_d;
			block_page_q     <= block_page_d;
			block_bytes_q    <= block_bytes_d;
			entries_left_q   <= entries_left_d;
			bytes_consumed_q <= bytes_consumed_d;
			finished_q       <= finished_d;
		end
	end

endmodule

// ===== rtl/rbw_out_reg.sv =====
// result register on the master side
module rbw_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rbw_pkg::result_t res,
	input  logic             res_valid,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [127:0]     m_tdata,
	output logic             m_tlast,
	output logic [1:0]       m_tuser
);

	logic             valid_q;
	rbw_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.patch_delta, res_q.patch_address};
	assign m_tlast  = res_q.is_last;
	assign m_tuser  = res_q.result_kind;

endmodule
